>>> hw/rtl/ufpp_pkg.sv
// ----------------------------------------------------------------------------
// ufpp_pkg
// Shared constants, payload types and register layout of the feedback
// packet pacer.
// ----------------------------------------------------------------------------
package ufpp_pkg;

   // ring geometry and loss threshold
   localparam int RING_DEPTH = 128;
   localparam int LOSS_LIMIT = 32;
   localparam int ENTRIES    = 8;
   localparam int ROWS       = 5;

   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int ENTRY_AW   = $clog2(ENTRIES);
   localparam int ROW_AW     = RING_AW - ENTRY_AW;
   localparam int RING_ROWS  = RING_DEPTH / ENTRIES;
   localparam int ROW_SEL_W  = $clog2(ROWS);

   // field widths
   localparam int FRAME_W    = 5;
   localparam int FB_W       = 8;
   localparam int ROWCNT_W   = 3;
   localparam int ERR_W      = 8;
   localparam int OUT_W      = 8;
   localparam int CSR_DW     = ENTRIES * FRAME_W;

   // register reset values
   localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET = 3'd1;
   localparam logic [FRAME_W-1:0]  NOMINAL_RESET   = 5'd6;

   // register indexes
   typedef enum logic [2:0] {
      CSR_FEEDBACK_BASE  = 3'd0,
      CSR_ROW_COUNT      = 3'd1,
      CSR_NOMINAL_COUNT  = 3'd2,
      CSR_PATTERN_ROW_0  = 3'd3,
      CSR_PATTERN_ROW_1  = 3'd4,
      CSR_PATTERN_ROW_2  = 3'd5,
      CSR_PATTERN_ROW_3  = 3'd6,
      CSR_PATTERN_ROW_4  = 3'd7
   } csr_index_type;

   // eight frame counts, entry 0 in the low bits
   typedef logic [ENTRIES-1:0][FRAME_W-1:0] ring_row_type;

   typedef struct packed {
      logic [FB_W-1:0]           feedback_base;
      logic [ROWCNT_W-1:0]       row_count;
      logic [FRAME_W-1:0]        nominal_count;
      ring_row_type [ROWS-1:0]   pattern;
   } cfg_type;

   // register setting right after reset
   localparam cfg_type CFG_RESET = '{
      feedback_base: '0,
      row_count:     ROW_COUNT_RESET,
      nominal_count: NOMINAL_RESET,
      pattern:       '0
   };

   typedef struct packed {
      logic            cmd;
      logic            status_good;
      logic [FB_W-1:0] fb_byte;
      logic            ends_transfer;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] frames;
      logic             synced;
      logic             sync_acquired;
      logic             sync_lost;
   } rsp_type;

endpackage

>>> hw/rtl/usb_feedback_packet_pacer.sv
// ----------------------------------------------------------------------------
// usb_feedback_packet_pacer
// Paces isochronous playback packet sizes from device feedback packets.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the result side stalls,
// and answers each item with one result: the item sits in the input register,
// where the whole pacing update for that item (pattern row write, ring entry
// read, sync and error tracking) is done in a single pass, and its result in
// the result register. Throughput is bounded by that single-pass update of the
// pacing state, which finishes every cycle. The frame ring is sixteen rows of
// eight entries with a valid flag per row, so it reads as zero right after
// reset with no clearing pass. The user must write configuration registers
// through the csr port only while it is idle; the block does not enforce it.
module usb_feedback_packet_pacer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ufpp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ufpp_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  ufpp_pkg::csr_index_type       csr_index,
   input  logic [ufpp_pkg::CSR_DW-1:0]   csr_wdata
);
   import ufpp_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   req_type   req_ff;
   logic      req_valid_ff, req_valid_in;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   core_rsp;
   logic      advance;
   logic      accept;

   // configuration register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FEEDBACK_BASE:  cfg_in.feedback_base  = csr_wdata[FB_W-1:0];
            CSR_ROW_COUNT:      cfg_in.row_count      = csr_wdata[ROWCNT_W-1:0];
            CSR_NOMINAL_COUNT:  cfg_in.nominal_count  = csr_wdata[FRAME_W-1:0];
            CSR_PATTERN_ROW_0:  cfg_in.pattern[0]     = csr_wdata;
            CSR_PATTERN_ROW_1:  cfg_in.pattern[1]     = csr_wdata;
            CSR_PATTERN_ROW_2:  cfg_in.pattern[2]     = csr_wdata;
            CSR_PATTERN_ROW_3:  cfg_in.pattern[3]     = csr_wdata;
            CSR_PATTERN_ROW_4:  cfg_in.pattern[4]     = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: the item in the input register moves on when the result
   // register is empty or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   // pacing state and ring
   ufpp_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/ufpp_core.sv
// ----------------------------------------------------------------------------
// ufpp_core
// Pacing state, frame ring and the single-pass update for one item.
// ----------------------------------------------------------------------------
module ufpp_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  ufpp_pkg::req_type req,
   input  ufpp_pkg::cfg_type cfg,
   output ufpp_pkg::rsp_type rsp
);
   import ufpp_pkg::*;

   // ring storage, one row of eight entries per feedback item
   ring_row_type              ring_mem [RING_ROWS];
   logic [RING_ROWS-1:0]      row_valid_ff;

   logic [ROW_AW-1:0]         wr_row_ff, wr_row_in;
   logic [ROW_AW-1:0]         start_row_ff, start_row_in;
   logic [RING_AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                      in_transfer_ff, in_transfer_in;
   logic                      skip_rest_ff, skip_rest_in;
   logic                      synced_ff, synced_in;
   logic [ERR_W-1:0]          error_run_ff, error_run_in;

   logic [FB_W-1:0]           row_off;
   logic                      fb_valid;
   logic [ERR_W-1:0]          err_inc;
   logic                      lost_hit;
   ring_row_type              wr_data;
   logic [OUT_W-1:0]          wr_sum;
   logic [ROW_AW-1:0]         start_row;
   logic [ROW_AW-1:0]         wr_row_next;
   logic [RING_AW-1:0]        ahead_dist, behind_dist;
   logic                      ahead, behind;
   logic [ROW_AW-1:0]         rd_row;
   logic [ENTRY_AW-1:0]       rd_sel;
   logic [FRAME_W-1:0]        rd_entry;
   logic                      ring_we;

   // feedback byte decode
   assign row_off  = req.fb_byte - cfg.feedback_base;
   assign fb_valid = req.status_good
                   && (req.fb_byte >= cfg.feedback_base)
                   && (row_off < FB_W'(cfg.row_count))
                   && (row_off < FB_W'(ROWS));

   // saturating error run and loss check
   assign err_inc  = (error_run_ff == '1) ? error_run_ff : error_run_ff + 1'b1;
   assign lost_hit = !fb_valid && synced_ff && (err_inc > ERR_W'(LOSS_LIMIT));

   // row to write and its sum
   always_comb begin
      wr_sum = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         wr_data[i] = fb_valid ? cfg.pattern[row_off[ROW_SEL_W-1:0]][i]
                               : cfg.nominal_count;
         wr_sum     = wr_sum + OUT_W'(wr_data[i]);
      end
   end

   // sync window check at transfer end
   assign start_row   = in_transfer_ff ? start_row_ff : wr_row_ff;
   assign wr_row_next = wr_row_ff + 1'b1;
   assign ahead_dist  = {wr_row_next, ENTRY_AW'(0)} - rd_idx_ff;
   assign behind_dist = {start_row, ENTRY_AW'(0)} - rd_idx_ff;
   assign ahead       = ahead_dist < RING_AW'(RING_DEPTH / 2);
   assign behind      = behind_dist >= RING_AW'(RING_DEPTH / 2);

   // playback read, rows never written read as zero
   assign rd_row   = rd_idx_ff[RING_AW-1:ENTRY_AW];
   assign rd_sel   = rd_idx_ff[ENTRY_AW-1:0];
   assign rd_entry = row_valid_ff[rd_row] ? ring_mem[rd_row][rd_sel] : '0;

   // next state and result for the item at hand
   always_comb begin
      wr_row_in      = wr_row_ff;
      start_row_in   = start_row_ff;
      rd_idx_in      = rd_idx_ff;
      in_transfer_in = in_transfer_ff;
      skip_rest_in   = skip_rest_ff;
      synced_in      = synced_ff;
      error_run_in   = error_run_ff;
      ring_we        = 1'b0;
      rsp            = '0;

      if (req.cmd) begin
         if (synced_ff) begin
            rsp.frames = OUT_W'(rd_entry);
            rd_idx_in  = rd_idx_ff + 1'b1;
         end else begin
            rsp.frames = OUT_W'(cfg.nominal_count);
         end
      end else begin
         if (!in_transfer_ff) begin
            start_row_in = wr_row_ff;
         end
         in_transfer_in = 1'b1;

         if (skip_rest_ff) begin
            if (req.ends_transfer) begin
               skip_rest_in   = 1'b0;
               in_transfer_in = 1'b0;
            end
         end else if (lost_hit) begin
            // loss packet writes nothing
            synced_in     = 1'b0;
            error_run_in  = err_inc;
            rsp.sync_lost = 1'b1;
            if (req.ends_transfer) begin
               in_transfer_in = 1'b0;
            end else begin
               skip_rest_in = 1'b1;
            end
         end else begin
            if (fb_valid) begin
               error_run_in = '0;
            end else if (synced_ff) begin
               error_run_in = err_inc;
            end
            ring_we    = 1'b1;
            rsp.frames = wr_sum;
            wr_row_in  = wr_row_next;
            if (req.ends_transfer) begin
               if (!synced_ff && ahead && behind) begin
                  synced_in         = 1'b1;
                  error_run_in      = '0;
                  rsp.sync_acquired = 1'b1;
               end
               in_transfer_in = 1'b0;
            end
         end
      end
      rsp.synced = synced_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff   <= '0;
         wr_row_ff      <= '0;
         start_row_ff   <= '0;
         rd_idx_ff      <= '0;
         in_transfer_ff <= 1'b0;
         skip_rest_ff   <= 1'b0;
         synced_ff      <= 1'b0;
         error_run_ff   <= '0;
      end else if (fire) begin
         if (ring_we) begin
            row_valid_ff[wr_row_ff] <= 1'b1;
         end
         wr_row_ff      <= wr_row_in;
         start_row_ff   <= start_row_in;
         rd_idx_ff      <= rd_idx_in;
         in_transfer_ff <= in_transfer_in;
         skip_rest_ff   <= skip_rest_in;
         synced_ff      <= synced_in;
         error_run_ff   <= error_run_in;
      end
   end

   // ring row write
   always_ff @(posedge clock) begin
      if (fire && ring_we) begin
         ring_mem[wr_row_ff] <= wr_data;
      end
   end

   // skipping only happens inside an open transfer
   a_skip_in_transfer: assert property (@(posedge clock) disable iff (reset)
      skip_rest_ff |-> in_transfer_ff)
      else $error("skip_rest set outside a transfer");

   // loss drops sync and leaves nothing half open
   a_loss_drops_sync: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.sync_lost |=> !synced_ff && (skip_rest_ff || !in_transfer_ff))
      else $error("loss item left sync or transfer state inconsistent");

   // acquiring sync restarts the error run
   a_acquire_clears_errors: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.sync_acquired |=> synced_ff && (error_run_ff == '0))
      else $error("sync acquired without clearing the error run");

   // a synced playback request consumes exactly one entry
   a_read_advance: assert property (@(posedge clock) disable iff (reset)
      fire && req.cmd && synced_ff |=> rd_idx_ff == RING_AW'($past(rd_idx_ff) + 1'b1))
      else $error("read index did not advance by one");

endmodule

>>> tb/sv/usb_feedback_packet_pacer_tb.sv
// ----------------------------------------------------------------------------
// usb_feedback_packet_pacer_tb
// Self-checking bench for the feedback packet pacer. A directed table covers
// the field extremes, out-of-range feedback and the register limits. Random
// phases follow, each with a new register setting. They mix healthy feedback
// streams, error bursts that knock the pacer out of sync, and plain noise.
// Every accepted item is run through a local copy of the pacing state, and
// each result is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module usb_feedback_packet_pacer_tb;
   import ufpp_pkg::*;

   localparam int N_PHASES      = 8;
   localparam int PHASE_ITEMS   = 205;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_AT       = 400;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;

   typedef enum int {MODE_STREAM, MODE_BURST, MODE_NOISE} mode_type;
   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_type;

   typedef struct {
      step_kind_type      kind;
      csr_index_type      idx;
      logic [CSR_DW-1:0]  wdata;
      req_type            req;
      bit                 typed;
      rsp_type            rsp;
   } step_type;

   // block ports
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   csr_index_type       csr_index = CSR_FEEDBACK_BASE;
   logic [CSR_DW-1:0]   csr_wdata = '0;

   // local copy of the pacing state and the register setting
   logic [FRAME_W-1:0]  ring_q [RING_DEPTH];
   logic [RING_AW-1:0]  wr_ptr, rd_ptr, xfer_base;
   bit                  in_xfer, skipping, locked;
   logic [ERR_W-1:0]    err_run;
   logic [FB_W-1:0]     cfg_base;
   logic [ROWCNT_W-1:0] cfg_rows;
   logic [FRAME_W-1:0]  cfg_nominal;
   ring_row_type        cfg_pattern [ROWS];

   // results still owed by the block, oldest first
   rsp_type             owed_results [$];
   step_type            directed_steps [$];

   int                  cycle_count    = 0;
   int                  mismatch_count = 0;
   int                  items_sent     = 0;
   int                  syncs_seen     = 0;
   int                  losses_seen    = 0;
   int                  settings_used  = 0;
   int                  idle_pct       = 0;
   int                  stall_left     = 0;
   bit                  hold_done      = 1'b0;
   rsp_type             got, want;

   usb_feedback_packet_pacer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // pacing update for one accepted item
   task automatic pace_item(input req_type r, output rsp_type o);
      int                 row;
      int                 hi_row;
      logic [OUT_W-1:0]   sum;
      logic [FRAME_W-1:0] v;
      logic [RING_AW-1:0] slot, ahead_d, behind_d;
      bit                 good, acq, lost, writes;
      sum    = '0;
      acq    = 1'b0;
      lost   = 1'b0;
      if (r.cmd) begin
         // playback request: next ring entry while synced
         if (locked) begin
            sum    = OUT_W'(ring_q[rd_ptr]);
            rd_ptr = rd_ptr + 1'b1;
         end else begin
            sum = OUT_W'(cfg_nominal);
         end
      end else begin
         if (!in_xfer) begin
            xfer_base = wr_ptr;
            in_xfer   = 1'b1;
         end
         if (skipping) begin
            // rest of a lost transfer is dropped
            if (r.ends_transfer) begin
               skipping = 1'b0;
               in_xfer  = 1'b0;
            end
         end else begin
            good   = 1'b0;
            row    = 0;
            writes = 1'b1;
            hi_row = (cfg_rows < ROWS) ? int'(cfg_rows) : ROWS;
            if (r.status_good && r.fb_byte >= cfg_base) begin
               row  = int'(r.fb_byte) - int'(cfg_base);
               good = row < hi_row;
            end
            // error run only counts while synced
            if (good) begin
               err_run = '0;
            end else if (locked) begin
               if (err_run < 8'd255) err_run = err_run + 1'b1;
               if (err_run > LOSS_LIMIT) begin
                  locked = 1'b0;
                  lost   = 1'b1;
                  writes = 1'b0;
                  if (r.ends_transfer) in_xfer = 1'b0;
                  else skipping = 1'b1;
               end
            end
            if (writes) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  v           = good ? cfg_pattern[row][i] : cfg_nominal;
                  slot        = RING_AW'(wr_ptr + i);
                  ring_q[slot] = v;
                  sum         = sum + OUT_W'(v);
               end
               wr_ptr = RING_AW'(wr_ptr + ENTRIES);
               // sync check at transfer end: writer just passed the reader
               if (r.ends_transfer) begin
                  if (!locked) begin
                     ahead_d  = wr_ptr - rd_ptr;
                     behind_d = xfer_base - rd_ptr;
                     if (ahead_d < RING_DEPTH / 2 && behind_d >= RING_DEPTH / 2) begin
                        locked  = 1'b1;
                        err_run = '0;
                        acq     = 1'b1;
                     end
                  end
                  in_xfer = 1'b0;
               end
            end
         end
      end
      o.frames        = sum;
      o.synced        = locked;
      o.sync_acquired = acq;
      o.sync_lost     = lost;
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // offer one item until it is taken, then log what it should produce
   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pace_item(item, predicted);
      owed_results.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      if (predicted.sync_acquired) syncs_seen++;
      if (predicted.sync_lost) losses_seen++;
      @(negedge clock);
   endtask

   task automatic maybe_gap();
      if ($urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // stop offering and wait until every owed result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_FEEDBACK_BASE:  cfg_base    = value[FB_W-1:0];
         CSR_ROW_COUNT:      cfg_rows    = value[ROWCNT_W-1:0];
         CSR_NOMINAL_COUNT:  cfg_nominal = value[FRAME_W-1:0];
         default:            cfg_pattern[int'(idx) - int'(CSR_PATTERN_ROW_0)] = value;
      endcase
      @(negedge clock);
   endtask

   function automatic step_type item_step(input logic c, input logic ok, input logic [7:0] fv,
                                          input logic ends, input bit typed,
                                          input logic [OUT_W-1:0] frames);
      step_type s;
      s.kind                 = STEP_ITEM;
      s.idx                  = CSR_FEEDBACK_BASE;
      s.wdata                = '0;
      s.req.cmd              = c;
      s.req.status_good      = ok;
      s.req.fb_byte          = fv;
      s.req.ends_transfer    = ends;
      s.typed                = typed;
      s.rsp.frames           = frames;
      s.rsp.synced           = 1'b0;
      s.rsp.sync_acquired    = 1'b0;
      s.rsp.sync_lost        = 1'b0;
      return s;
   endfunction

   function automatic step_type csr_step(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      step_type s;
      s       = item_step(1'b0, 1'b0, 8'd0, 1'b0, 1'b0, '0);
      s.kind  = STEP_CSR;
      s.idx   = idx;
      s.wdata = value;
      return s;
   endfunction

   // random item drawn for the current setting
   function automatic req_type draw_item(input mode_type mode);
      req_type it;
      int      hi;
      bit      in_range;
      it.cmd           = 1'($urandom_range(0, 1));
      it.status_good   = 1'($urandom_range(0, 1));
      it.fb_byte       = 8'($urandom_range(0, 255));
      it.ends_transfer = 1'($urandom_range(0, 1));
      hi = int'(cfg_base) + ((cfg_rows < ROWS) ? int'(cfg_rows) : ROWS) - 1;
      if (hi > 255) hi = 255;
      in_range = cfg_rows != 0 && int'(it.fb_byte) >= int'(cfg_base)
                 && int'(it.fb_byte) <= hi;
      case (mode)
         MODE_STREAM: begin
            it.status_good = $urandom_range(0, 15) != 0;
            if (cfg_rows != 0 && $urandom_range(0, 7) != 0)
               it.fb_byte = 8'($urandom_range(hi, int'(cfg_base)));
         end
         MODE_BURST: begin
            // mostly bad feedback, transfers rarely end
            it.cmd           = $urandom_range(0, 4) == 0;
            it.ends_transfer = $urandom_range(0, 7) == 0;
            if (in_range) it.status_good = 1'b0;
         end
         default: ;
      endcase
      return it;
   endfunction

   // one register setting followed by a run of random sequences
   task automatic run_phase(input int phase, input int n_items);
      logic [CSR_DW-1:0]   junk;
      logic [FB_W-1:0]     base;
      logic [ROWCNT_W-1:0] rows;
      logic [FRAME_W-1:0]  nom;
      ring_row_type        pat;
      int                  pick, sent, len;
      mode_type            mode;
      rsp_type             none;
      settle();
      pick = $urandom_range(0, 3);
      base = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : (pick == 2) ? 8'd251
             : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      rows = (pick < 8) ? 3'(1 + pick % 5) : (pick == 8) ? 3'd0 : 3'($urandom_range(6, 7));
      pick = $urandom_range(0, 3);
      nom  = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : 5'($urandom_range(0, 31));
      junk = CSR_DW'({$urandom, $urandom});
      write_reg(CSR_FEEDBACK_BASE, {junk[CSR_DW-1:FB_W], base});
      write_reg(CSR_ROW_COUNT, {junk[CSR_DW-1:ROWCNT_W], rows});
      write_reg(CSR_NOMINAL_COUNT, {junk[CSR_DW-1:FRAME_W], nom});
      for (int r = 0; r < ROWS; r++) begin
         pick = $urandom_range(0, 5);
         pat  = (pick == 0) ? '0 : (pick == 1) ? '1 : CSR_DW'({$urandom, $urandom});
         write_reg(csr_index_type'(int'(CSR_PATTERN_ROW_0) + r), pat);
      end
      csr_we <= 1'b0;
      settings_used++;
      // idling rate per phase, none at the end of the run
      idle_pct = (phase == N_PHASES - 1) ? 0 : (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 20 : 40;
      none = '0;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 9);
         mode = (pick < 6) ? MODE_STREAM : (pick < 8) ? MODE_BURST : MODE_NOISE;
         len  = (mode == MODE_STREAM) ? $urandom_range(8, 40)
                : (mode == MODE_BURST) ? $urandom_range(34, 50) : $urandom_range(2, 8);
         for (int k = 0; k < len && sent < n_items; k++) begin
            maybe_gap();
            send_item(draw_item(mode), 1'b0, none);
            sent++;
         end
      end
   endtask

   // receiver: random stall bursts plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
         end else if (stall_left == 0 && $urandom_range(1, 100) <= idle_pct) begin
            stall_left = $urandom_range(1, 4);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // result checker and run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, owed_results.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_data;
         if (owed_results.size() == 0) begin
            flag_mismatch("result with nothing expected");
         end else begin
            want = owed_results.pop_front();
            if (got.frames !== want.frames)
               flag_mismatch($sformatf("frames got %0d want %0d", got.frames, want.frames));
            if (got.synced !== want.synced)
               flag_mismatch($sformatf("synced got %0b want %0b", got.synced, want.synced));
            if (got.sync_acquired !== want.sync_acquired)
               flag_mismatch($sformatf("sync_acquired got %0b want %0b",
                                       got.sync_acquired, want.sync_acquired));
            if (got.sync_lost !== want.sync_lost)
               flag_mismatch($sformatf("sync_lost got %0b want %0b",
                                       got.sync_lost, want.sync_lost));
         end
      end
   end

   // stimulus
   initial begin : stimulus
      step_type s;
      bit       in_csr;
      foreach (ring_q[i]) ring_q[i] = '0;
      foreach (cfg_pattern[i]) cfg_pattern[i] = '0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      xfer_base   = '0;
      in_xfer     = 1'b0;
      skipping    = 1'b0;
      locked      = 1'b0;
      err_run     = '0;
      cfg_base    = '0;
      cfg_rows    = 3'd1;
      cfg_nominal = 5'd6;
      in_csr      = 1'b0;

      // directed table: reset defaults, nominal extremes, row limits, first sync
      directed_steps.push_back(item_step(1'b1, 1'b0, 8'd0,   1'b0, 1'b1, 8'd6));
      directed_steps.push_back(item_step(1'b0, 1'b0, 8'd0,   1'b0, 1'b1, 8'd48));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd0,   1'b0, 1'b1, 8'd0));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd1,   1'b1, 1'b1, 8'd48));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd255, 1'b1, 1'b1, 8'd48));
      directed_steps.push_back(item_step(1'b1, 1'b1, 8'd255, 1'b1, 1'b1, 8'd6));
      directed_steps.push_back(csr_step(CSR_NOMINAL_COUNT, 40'd31));
      directed_steps.push_back(item_step(1'b0, 1'b0, 8'd0,   1'b1, 1'b1, 8'd248));
      directed_steps.push_back(csr_step(CSR_NOMINAL_COUNT, 40'd0));
      directed_steps.push_back(item_step(1'b0, 1'b0, 8'd255, 1'b1, 1'b1, 8'd0));
      directed_steps.push_back(item_step(1'b1, 1'b0, 8'd0,   1'b0, 1'b1, 8'd0));
      directed_steps.push_back(csr_step(CSR_FEEDBACK_BASE, 40'd255));
      directed_steps.push_back(csr_step(CSR_ROW_COUNT, 40'd7));
      directed_steps.push_back(csr_step(CSR_PATTERN_ROW_0, 40'hFF_FFFF_FFFF));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd255, 1'b0, 1'b1, 8'd248));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd254, 1'b1, 1'b1, 8'd0));
      directed_steps.push_back(csr_step(CSR_FEEDBACK_BASE, 40'd251));
      directed_steps.push_back(csr_step(CSR_ROW_COUNT, 40'd5));
      directed_steps.push_back(csr_step(CSR_PATTERN_ROW_4, 40'h08_4210_8421));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd255, 1'b1, 1'b1, 8'd8));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd250, 1'b1, 1'b1, 8'd0));
      // a byte that would select a sixth row is invalid
      directed_steps.push_back(csr_step(CSR_FEEDBACK_BASE, 40'd250));
      directed_steps.push_back(csr_step(CSR_ROW_COUNT, 40'd6));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd255, 1'b1, 1'b1, 8'd0));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd254, 1'b1, 1'b1, 8'd8));
      // zero rows: nothing is valid; keep writing until the ring wraps into sync
      directed_steps.push_back(csr_step(CSR_ROW_COUNT, 40'd0));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd250, 1'b1, 1'b1, 8'd0));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd250, 1'b1, 1'b0, 8'd0));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd250, 1'b1, 1'b0, 8'd0));
      directed_steps.push_back(item_step(1'b0, 1'b1, 8'd250, 1'b1, 1'b0, 8'd0));
      directed_steps.push_back(item_step(1'b1, 1'b0, 8'd0,   1'b0, 1'b0, 8'd0));
      directed_steps.push_back(item_step(1'b1, 1'b1, 8'd170, 1'b1, 1'b0, 8'd0));

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_pct = 25;
      foreach (directed_steps[n]) begin
         s = directed_steps[n];
         if (s.kind == STEP_CSR) begin
            if (!in_csr) settle();
            write_reg(s.idx, s.wdata);
            in_csr = 1'b1;
         end else begin
            if (in_csr) csr_we <= 1'b0;
            else maybe_gap();
            in_csr = 1'b0;
            send_item(s.req, s.typed, s.rsp);
         end
      end
      settings_used++;

      for (int p = 0; p < N_PHASES; p++) run_phase(p, PHASE_ITEMS);

      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d items under %0d register settings, %0d sync gains, %0d sync losses",
               items_sent, settings_used, syncs_seen, losses_seen);
      $display("one receiver hold-off of %0d cycles, %0d mismatches", HOLD_CYCLES, mismatch_count);
      if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
